// ===== src/mbr_pkg.sv =====
// shared types, constants and codes of the margolus block rotate unit
package mbr_pkg;

  localparam int MAX_SIDE_DEF  = 64;
  localparam int MAX_ENZ_DEF   = 4;
  localparam int BASE_SLOTS    = 3;
  localparam int GRID_SIDE_RST = 64;

  localparam int DATA_W     = 64;
  localparam int CELL_IDX_W = 12;
  localparam int FUNC_W     = 2;
  localparam int SLOT_IN_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // widths that cover every legal MAX_ENZYMES (at most eight words per cell)
  localparam int SLOT_FW  = 3;
  localparam int NSLOT_FW = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENZYME_COUNT = CFG_IDX_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ROTATE = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROT,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_0,
    PH_1,
    PH_2,
    PH_3
  } phase_e;

  typedef enum logic [1:0] {
    POS_0,
    POS_1,
    POS_2,
    POS_3
  } pos_e;

  typedef enum logic [1:0] {
    WSRC_ITEM,
    WSRC_RDATA,
    WSRC_SAVED
  } wsrc_e;

  typedef struct packed {
    logic               load_item;
    logic               load_pos;
    logic               save_en;
    logic               out_load;
    logic               rd_en;
    logic               wr_en;
    pos_e               rd_pos;
    pos_e               wr_pos;
    logic [SLOT_FW-1:0] rd_slot;
    logic [SLOT_FW-1:0] wr_slot;
    logic               use_item_slot;
    wsrc_e              wr_src;
  } cmd_t;

  typedef struct packed {
    logic                err;
    logic [FUNC_W-1:0]   func;
    logic [NSLOT_FW-1:0] nslots;
  } stat_t;

endpackage

// ===== src/mbr_ctrl.sv =====
// controller: item sequencing and the four-phase per-slot rotate schedule
module mbr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  mbr_pkg::stat_t stat_i,
  output mbr_pkg::cmd_t  cmd_o
);
  import mbr_pkg::*;

  state_e              state_q, state_d;
  phase_e              ph_q, ph_d;
  logic [NSLOT_FW-1:0] cnt_q, cnt_d;
  logic [NSLOT_FW-1:0] cnt_m1;
  logic                out_valid_q, out_valid_d;
  logic                last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cnt_m1      = cnt_q - NSLOT_FW'(1);
  // slot counter past the last slot: only the previous slot's writes remain
  assign last        = (cnt_q == stat_i.nslots);

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CHECK;
        end
      end

      ST_CHECK: begin
        state_d = ST_FINISH;
        if (!stat_i.err) begin
          case (stat_i.func)
            FUNC_ROTATE: begin
              cmd_o.load_pos = 1'b1;
              ph_d           = PH_0;
              cnt_d          = '0;
              state_d        = ST_ROT;
            end
            FUNC_WRITE: begin
              cmd_o.wr_en         = 1'b1;
              cmd_o.wr_pos        = POS_0;
              cmd_o.use_item_slot = 1'b1;
              cmd_o.wr_src        = WSRC_ITEM;
            end
            FUNC_READ: begin
              cmd_o.rd_en         = 1'b1;
              cmd_o.rd_pos        = POS_0;
              cmd_o.use_item_slot = 1'b1;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_ROT: begin
        case (ph_q)
          PH_0: begin
            // read p0 of this slot, p2 of the previous slot takes p3's word
            if (!last) begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_pos  = POS_0;
              cmd_o.rd_slot = SLOT_FW'(cnt_q);
            end
            if (cnt_q != '0) begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_pos  = POS_2;
              cmd_o.wr_slot = SLOT_FW'(cnt_m1);
              cmd_o.wr_src  = WSRC_RDATA;
            end
            ph_d = PH_1;
          end
          PH_1: begin
            // keep old p0, read p1; p3 of the previous slot takes its old p0
            if (!last) begin
              cmd_o.save_en = 1'b1;
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_pos  = POS_1;
              cmd_o.rd_slot = SLOT_FW'(cnt_q);
            end
            if (cnt_q != '0) begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_pos  = POS_3;
              cmd_o.wr_slot = SLOT_FW'(cnt_m1);
              cmd_o.wr_src  = WSRC_SAVED;
            end
            if (last) begin
              ph_d    = PH_0;
              cnt_d   = '0;
              state_d = ST_FINISH;
            end else begin
              ph_d = PH_2;
            end
          end
          PH_2: begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_pos  = POS_0;
            cmd_o.wr_slot = SLOT_FW'(cnt_q);
            cmd_o.wr_src  = WSRC_RDATA;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_pos  = POS_2;
            cmd_o.rd_slot = SLOT_FW'(cnt_q);
            ph_d          = PH_3;
          end
          PH_3: begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_pos  = POS_1;
            cmd_o.wr_slot = SLOT_FW'(cnt_q);
            cmd_o.wr_src  = WSRC_RDATA;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_pos  = POS_3;
            cmd_o.rd_slot = SLOT_FW'(cnt_q);
            cnt_d         = cnt_q + NSLOT_FW'(1);
            ph_d          = PH_0;
          end
          default: begin
            ph_d = PH_0;
          end
        endcase
      end

      ST_FINISH: begin
        // result register frees up or is being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mbr_dpath.sv =====
// datapath: configuration, item registers, block positions, cell store and result
module mbr_dpath #(
  parameter int MAX_SIDE    = mbr_pkg::MAX_SIDE_DEF,
  parameter int MAX_ENZYMES = mbr_pkg::MAX_ENZ_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [mbr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [mbr_pkg::FUNC_W-1:0]     func_i,
  input  logic [mbr_pkg::CELL_IDX_W-1:0] cell_index_i,
  input  logic                           direction_i,
  input  logic [mbr_pkg::SLOT_IN_W-1:0]  slot_i,
  input  logic [mbr_pkg::DATA_W-1:0]     write_data_i,
  input  mbr_pkg::cmd_t                  cmd_i,
  output mbr_pkg::stat_t                 stat_o,
  output logic [mbr_pkg::DATA_W-1:0]     read_data_o,
  output logic                           status_o
);
  import mbr_pkg::*;

  localparam int CELL_WORDS = BASE_SLOTS + MAX_ENZYMES;
  localparam int CELL_TOTAL = MAX_SIDE * MAX_SIDE;
  localparam int MEM_DEPTH  = CELL_TOTAL * CELL_WORDS;
  localparam int CW         = $clog2(CELL_TOTAL);
  localparam int CELLS_W    = CW + 1;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int SLOT_W     = $clog2(CELL_WORDS);
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int SUM_W      = ((CELLS_W > CELL_IDX_W) ? CELLS_W : CELL_IDX_W) + 1;
  localparam int SIDE_RST   = (GRID_SIDE_RST > MAX_SIDE) ? MAX_SIDE : GRID_SIDE_RST;
  localparam int CELLS_RST  = SIDE_RST * SIDE_RST;

  // effective configuration, already clamped
  logic [SIDE_W-1:0]     side_q;
  logic [CELLS_W-1:0]    cells_q;
  logic [NSLOT_FW-1:0]   nslots_q;
  logic [SIDE_W-1:0]     side_cl;
  logic [2*SIDE_W-1:0]   side_sq;
  logic [SLOT_IN_W-1:0]  enz_cl;

  logic [FUNC_W-1:0]     func_q;
  logic [CELL_IDX_W-1:0] cidx_q;
  logic                  dir_q;
  logic [SLOT_IN_W-1:0]  slot_q;
  logic [DATA_W-1:0]     wdata_q;

  logic [CW-1:0]         p1_q, p2_q, p3_q;
  logic [SUM_W-1:0]      t_ext, cells_ext, a_ext, b_ext, s1, s2, s3;
  logic                  idx_bad, slot_bad, err;

  logic [DATA_W-1:0]     mem [MEM_DEPTH];
  logic [DATA_W-1:0]     rdata_q, saved_q, wr_data;
  logic [CW-1:0]         rd_cell, wr_cell;
  logic [SLOT_W-1:0]     rd_slot, wr_slot;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;

  logic [DATA_W-1:0]     out_data_q;
  logic                  out_status_q;

  always_comb begin
    if (cfg_data_i < CFG_DATA_W'(2)) begin
      side_cl = SIDE_W'(2);
    end else if (32'(cfg_data_i) > MAX_SIDE) begin
      side_cl = SIDE_W'(MAX_SIDE);
    end else begin
      side_cl = SIDE_W'(cfg_data_i);
    end
    side_sq = (2*SIDE_W)'(side_cl) * (2*SIDE_W)'(side_cl);
    if (32'(cfg_data_i[SLOT_IN_W-1:0]) > MAX_ENZYMES) begin
      enz_cl = SLOT_IN_W'(MAX_ENZYMES);
    end else begin
      enz_cl = cfg_data_i[SLOT_IN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= SIDE_W'(SIDE_RST);
      cells_q  <= CELLS_W'(CELLS_RST);
      nslots_q <= NSLOT_FW'(BASE_SLOTS);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_GRID_SIDE) begin
        side_q  <= side_cl;
        cells_q <= CELLS_W'(side_sq);
      end else if (cfg_index_i == CFG_ENZYME_COUNT) begin
        nslots_q <= NSLOT_FW'(BASE_SLOTS) + NSLOT_FW'(enz_cl);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q  <= func_i;
      cidx_q  <= cell_index_i;
      dir_q   <= direction_i;
      slot_q  <= slot_i;
      wdata_q <= write_data_i;
    end
  end

  // range checks and the three neighbour positions, wrapped by one subtract
  always_comb begin
    t_ext     = SUM_W'(cidx_q);
    cells_ext = SUM_W'(cells_q);
    a_ext     = dir_q ? SUM_W'(side_q) : SUM_W'(1);
    b_ext     = dir_q ? SUM_W'(1) : SUM_W'(side_q);
    s1        = t_ext + a_ext;
    s2        = t_ext + a_ext + b_ext;
    s3        = t_ext + b_ext;
    if (s1 >= cells_ext) s1 = s1 - cells_ext;
    if (s2 >= cells_ext) s2 = s2 - cells_ext;
    if (s3 >= cells_ext) s3 = s3 - cells_ext;
    idx_bad  = (t_ext >= cells_ext);
    slot_bad = (NSLOT_FW'(slot_q) >= nslots_q);
    err      = idx_bad || (func_q == FUNC_UNUSED)
            || (((func_q == FUNC_WRITE) || (func_q == FUNC_READ)) && slot_bad);
  end

  assign stat_o.err    = err;
  assign stat_o.func   = func_q;
  assign stat_o.nslots = nslots_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pos) begin
      p1_q <= CW'(s1);
      p2_q <= CW'(s2);
      p3_q <= CW'(s3);
    end
  end

  function automatic logic [CW-1:0] pick_cell(pos_e sel, logic [CW-1:0] c0,
                                              logic [CW-1:0] c1, logic [CW-1:0] c2,
                                              logic [CW-1:0] c3);
    logic [CW-1:0] c;
    case (sel)
      POS_0:   c = c0;
      POS_1:   c = c1;
      POS_2:   c = c2;
      POS_3:   c = c3;
      default: c = c0;
    endcase
    return c;
  endfunction

  always_comb begin
    rd_cell = pick_cell(cmd_i.rd_pos, CW'(cidx_q), p1_q, p2_q, p3_q);
    wr_cell = pick_cell(cmd_i.wr_pos, CW'(cidx_q), p1_q, p2_q, p3_q);
    rd_slot = cmd_i.use_item_slot ? SLOT_W'(slot_q) : SLOT_W'(cmd_i.rd_slot);
    wr_slot = cmd_i.use_item_slot ? SLOT_W'(slot_q) : SLOT_W'(cmd_i.wr_slot);
    rd_addr = ADDR_W'(rd_cell) * ADDR_W'(CELL_WORDS) + ADDR_W'(rd_slot);
    wr_addr = ADDR_W'(wr_cell) * ADDR_W'(CELL_WORDS) + ADDR_W'(wr_slot);
    case (cmd_i.wr_src)
      WSRC_ITEM:  wr_data = wdata_q;
      WSRC_RDATA: wr_data = rdata_q;
      WSRC_SAVED: wr_data = saved_q;
      default:    wr_data = wdata_q;
    endcase
  end

  // one write and one read a cycle; a read of the word being written sees the new word
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      if (cmd_i.wr_en && (wr_addr == rd_addr)) begin
        rdata_q <= wr_data;
      end else begin
        rdata_q <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_en) begin
      saved_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= err;
      out_data_q   <= (!err && (func_q == FUNC_READ)) ? rdata_q : '0;
    end
  end

  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;

endmodule

// ===== src/margolus_block_rotate.sv =====
// top level: 2x2 block rotation over a toroidal grid of multi-word cells
//
// Input channel (in_valid_i / in_ready_o) carries one item: func, cell_index,
// direction, slot and write_data. Output channel (out_valid_o / out_ready_i)
// returns one item per input item, read_data and status, in order.
// Config channel (cfg_valid_i / cfg_ready_o, always ready) writes grid_side
// at index 0 and enzyme_count at index 1; other indexes are ignored.
// Items are handled one at a time. A write, read or refused item goes from
// the check state to the finish state; a rotate runs four phases per slot and
// a closing pass for the last slot's writes, paced by the cell store doing one
// read and one write per cycle, four of each per slot. The next item can be
// taken in the same cycle that the result shows.
// A finished result sits in an output register; a new item is accepted
// while it waits, and a stalled receiver holds the block only when the next
// result is ready. Reset clears control and config to 64 columns, no
// enzymes; cell words are undefined until written.
module margolus_block_rotate #(
  parameter int MAX_SIDE    = mbr_pkg::MAX_SIDE_DEF,
  parameter int MAX_ENZYMES = mbr_pkg::MAX_ENZ_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mbr_pkg::FUNC_W-1:0]     func_i,
  input  logic [mbr_pkg::CELL_IDX_W-1:0] cell_index_i,
  input  logic                           direction_i,
  input  logic [mbr_pkg::SLOT_IN_W-1:0]  slot_i,
  input  logic [mbr_pkg::DATA_W-1:0]     write_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mbr_pkg::DATA_W-1:0]     read_data_o,
  output logic                           status_o
);
  import mbr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  mbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mbr_dpath #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_ENZYMES(MAX_ENZYMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (func_i),
    .cell_index_i(cell_index_i),
    .direction_i (direction_i),
    .slot_i      (slot_i),
    .write_data_i(write_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .read_data_o (read_data_o),
    .status_o    (status_o)
  );

endmodule

// ===== src/mbr_checker.sv =====
// port-level checks of the block rotate unit, bound to the top level
module mbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [6:0]  cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  func_i,
  input logic [11:0] cell_index_i,
  input logic        direction_i,
  input logic [2:0]  slot_i,
  input logic [63:0] write_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] read_data_o,
  input logic        status_o
);

  // one item in flight: taking an item closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // a fresh result only appears while the input side is closed
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in flight");

  // a refused item never carries data
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (read_data_o == 64'd0))
    else $error("refused item carries nonzero read data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(read_data_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind margolus_block_rotate mbr_checker u_mbr_checker (.*);
